// ----- rtl/core/sors_pkg.sv -----
package sors_pkg;

  // width of one table entry: divisor sums, then their prefix sums (mod 2^32)
  localparam int unsigned DataW = 32;

  typedef logic [DataW-1:0] data_t;

endpackage

// ----- rtl/core/sors_ram.sv -----
module sors_ram #(
  parameter int unsigned Depth = 65537,
  parameter int unsigned AddrW = 17
) (
  input  logic                 clk_i,
  input  logic [AddrW-1:0]     addr_i,
  input  logic                 we_i,
  input  sors_pkg::data_t      wdata_i,
  output sors_pkg::data_t      rdata_o
);

  sors_pkg::data_t mem [Depth];
  sors_pkg::data_t rdata_q;

  // single port, read-before-write, registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sum_of_remainders_sieve.sv -----
// Sum-of-remainders engine. A query n (saturated to MAX_N) returns
// sum over i = 1..n of (n mod i), formed as n*n minus the prefix sum of
// sigma(i), modulo 2^32. All state sits in one single-port table of MAX_N+1
// 32-bit words. The first query after reset builds that table: a clearing
// pass over all MAX_N+1 words, a divisor sieve that adds d into every multiple
// of d with a read state and a write state per touch, and an in-place prefix
// pass with a read and a write per entry. Every later query steps through
// accept, table read with the square, and result. start is taken while busy
// is low; the result appears on remainder_sum_o for exactly one cycle with
// done_o high and cannot be stalled, so capture it then.
module sum_of_remainders_sieve #(
  parameter int unsigned MAX_N = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [16:0] query_n_i,
  output logic        done_o,
  output logic [31:0] remainder_sum_o
);

  localparam int unsigned AW = $clog2(MAX_N + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLR    = 3'd1;
  localparam logic [2:0] S_SV_RD  = 3'd2;
  localparam logic [2:0] S_SV_WR  = 3'd3;
  localparam logic [2:0] S_PF_RD  = 3'd4;
  localparam logic [2:0] S_PF_WR  = 3'd5;
  localparam logic [2:0] S_LK_RD  = 3'd6;
  localparam logic [2:0] S_LK_RES = 3'd7;

  localparam logic [AW-1:0] MaxNA  = AW'(MAX_N);
  localparam logic [AW:0]   MaxNA1 = (AW+1)'(MAX_N);
  localparam logic [31:0]   MaxN32 = 32'(MAX_N);

  logic [2:0]      state_q, state_d;
  logic            ready_q, ready_d;
  logic [AW-1:0]   n_q, n_d;
  logic [AW-1:0]   cnt_q, cnt_d;   // clear / prefix index
  logic [AW-1:0]   d_q, d_d;       // sieve divisor
  logic [AW-1:0]   m_q, m_d;       // sieve multiple
  sors_pkg::data_t acc_q, acc_d;   // running prefix sum
  sors_pkg::data_t sq_q, sq_d;

  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  sors_pkg::data_t mem_wdata, mem_rdata;

  logic [31:0]     n_ext, n_sat;
  logic [AW:0]     m_next, d_next;
  logic            accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign n_ext  = 32'(query_n_i);
  assign n_sat  = (n_ext > MaxN32) ? MaxN32 : n_ext;
  assign m_next = {1'b0, m_q} + {1'b0, d_q};
  assign d_next = {1'b0, d_q} + (AW+1)'(1);

  sors_ram #(
    .Depth (MAX_N + 1),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    ready_d   = ready_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    d_d       = d_q;
    m_d       = m_q;
    acc_d     = acc_q;
    sq_d      = sq_q;
    mem_addr  = n_q;
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          n_d = n_sat[AW-1:0];
          if (ready_q) begin
            state_d = S_LK_RD;
          end else begin
            // first beat after reset: build the table
            cnt_d   = '0;
            state_d = S_CLR;
          end
        end
      end
      S_CLR: begin
        mem_addr = cnt_q;
        mem_we   = 1'b1;
        cnt_d    = cnt_q + AW'(1);
        if (cnt_q == MaxNA) begin
          d_d     = AW'(1);
          m_d     = AW'(1);
          state_d = S_SV_RD;
        end
      end
      S_SV_RD: begin
        mem_addr = m_q;
        state_d  = S_SV_WR;
      end
      S_SV_WR: begin
        // sigma[m] += d
        mem_addr  = m_q;
        mem_we    = 1'b1;
        mem_wdata = mem_rdata + sors_pkg::data_t'(d_q);
        state_d   = S_SV_RD;
        if (m_next > MaxNA1) begin
          if (d_next > MaxNA1) begin
            cnt_d   = AW'(1);
            acc_d   = '0;
            state_d = S_PF_RD;
          end else begin
            d_d = d_next[AW-1:0];
            m_d = d_next[AW-1:0];
          end
        end else begin
          m_d = m_next[AW-1:0];
        end
      end
      S_PF_RD: begin
        mem_addr = cnt_q;
        state_d  = S_PF_WR;
      end
      S_PF_WR: begin
        mem_addr  = cnt_q;
        mem_we    = 1'b1;
        mem_wdata = acc_q + mem_rdata;
        acc_d     = mem_wdata;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == MaxNA) begin
          ready_d = 1'b1;
          state_d = S_LK_RD;
        end else begin
          state_d = S_PF_RD;
        end
      end
      S_LK_RD: begin
        mem_addr = n_q;
        sq_d     = 32'(n_q) * 32'(n_q);
        state_d  = S_LK_RES;
      end
      S_LK_RES: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  // payload and loop counters, no reset needed
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    cnt_q <= cnt_d;
    d_q   <= d_d;
    m_q   <= m_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
  end

  // result beat: square minus prefix sigma, mod 2^32
  assign done_o          = (state_q == S_LK_RES);
  assign remainder_sum_o = sq_q - mem_rdata;

`ifndef ASSERT_OFF
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beats back to back");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accepting a query");

  a_build_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR || state_q == S_SV_WR || state_q == S_PF_RD) |-> !ready_q)
    else $error("table build while marked ready");

  a_done_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_LK_RD)
    else $error("result without table lookup");
`endif

endmodule

// ----- test/tb_sum_of_remainders_sieve.sv -----
module tb_sum_of_remainders_sieve;

  localparam int unsigned MaxN = 65536;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [16:0] query_n_i;
  logic        done_o;
  logic [31:0] remainder_sum_o;

  sum_of_remainders_sieve #(.MAX_N(MaxN)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .query_n_i      (query_n_i),
    .done_o         (done_o),
    .remainder_sum_o(remainder_sum_o)
  );

  // sigma(i) and its running sum, both kept mod 2^32 as the block does
  logic [31:0] sigma_tab [0:MaxN];
  logic [31:0] sigma_prefix [0:MaxN];

  logic [16:0] query_queue [$];
  logic [31:0] remainder_expected [$];
  int unsigned fail_count = 0;
  int unsigned idle_left;
  bit          all_sent;

  // sum of divisors by adding each d into all of its multiples
  task automatic build_sigma_prefix();
    int unsigned d;
    int unsigned m;
    for (m = 0; m <= MaxN; m++) sigma_tab[m] = '0;
    for (d = 1; d <= MaxN; d++) begin
      for (m = d; m <= MaxN; m += d) sigma_tab[m] += d;
    end
    sigma_prefix[0] = '0;
    for (m = 1; m <= MaxN; m++) sigma_prefix[m] = sigma_prefix[m-1] + sigma_tab[m];
  endtask

  // n*n minus prefix sigma, with n saturated to MaxN, the top of the table
  function automatic logic [31:0] remainder_sum_of(logic [16:0] n_raw);
    logic [31:0] n_sat;
    logic [63:0] square;
    n_sat = (n_raw > MaxN) ? MaxN : n_raw;
    square = n_sat * n_sat;
    return square[31:0] - sigma_prefix[n_sat];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver: one query per beat, random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      query_n_i <= '0;
      idle_left <= 0;
      all_sent  <= 1'b0;
    end else begin
      if (start && !busy) begin
        remainder_expected.push_back(remainder_sum_of(query_n_i));
      end
      if (start && busy) begin
        // hold the beat until it is taken
      end else if (idle_left > 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (query_queue.size() > 0) begin
        start     <= 1'b1;
        query_n_i <= query_queue.pop_front();
        idle_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
      end else begin
        start    <= 1'b0;
        all_sent <= 1'b1;
      end
    end
  end

  // monitor: results cannot be held off, so check each strobe as it comes
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (remainder_expected.size() == 0) begin
        $error("remainder_sum: unexpected result %0d", remainder_sum_o);
        fail_count++;
      end else begin
        if (remainder_sum_o !== remainder_expected[0]) begin
          $error("remainder_sum: expected %0d, actual %0d",
                 remainder_expected[0], remainder_sum_o);
          fail_count++;
        end
        void'(remainder_expected.pop_front());
      end
    end
  end

  initial begin
    int unsigned k;
    rst_ni     = 1'b0;
    build_sigma_prefix();

    // directed: small n, powers of two, the top of the table, saturation
    query_queue.push_back(17'd0);
    query_queue.push_back(17'd1);
    query_queue.push_back(17'd2);
    query_queue.push_back(17'd3);
    query_queue.push_back(17'd4);
    query_queue.push_back(17'd5);
    query_queue.push_back(17'd6);
    query_queue.push_back(17'd12);
    query_queue.push_back(17'd97);
    query_queue.push_back(17'd1024);
    query_queue.push_back(17'd4096);
    query_queue.push_back(17'd32768);
    query_queue.push_back(17'd65521);
    query_queue.push_back(17'd65535);
    query_queue.push_back(17'd65536);
    query_queue.push_back(17'd65537);
    query_queue.push_back(17'd98304);
    query_queue.push_back(17'd131071);
    query_queue.push_back(17'd0);

    // random: mostly inside the table, some above it
    for (k = 0; k < 650; k++) begin
      case ($urandom_range(0, 9))
        0:       query_queue.push_back($urandom_range(0, 131071));
        1:       query_queue.push_back($urandom_range(0, 64));
        2:       query_queue.push_back($urandom_range(65500, 65536));
        default: query_queue.push_back($urandom_range(0, 65536));
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (all_sent && remainder_expected.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && remainder_expected.size() == 0) begin
      $display("sum_of_remainders_sieve regression: pass");
    end else begin
      $display("sum_of_remainders_sieve regression: fail");
    end
    $finish;
  end

  // the first query pays for the whole table build, so allow plenty
  initial begin
    #40000000;
    $display("sum_of_remainders_sieve regression: fail");
    $finish;
  end

endmodule
